### hdl/stbr_pkg.sv
// shared constants, types and codes for the scanline background renderer
package stbr_pkg;

  localparam int VRAM_BYTES     = 8192;
  localparam int VRAM_AW        = $clog2(VRAM_BYTES);
  localparam int TILES_PER_LINE = 20;
  localparam int VISIBLE_LINES  = 144;
  localparam int LAST_LINE      = 153;

  localparam logic [VRAM_AW-1:0] MAP_BASE       = VRAM_AW'(13'h1800);
  localparam logic [7:0]         LINE_RESET     = 8'd144;
  localparam logic [15:0]        PRESCALE_RESET = 16'd279;

  // input action codes
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_VRAM_WR = 2'd1;
  localparam logic [1:0] ACT_CTRL_WR = 2'd2;

  // result kind codes
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ROW    = 2'd1;
  localparam logic [1:0] KIND_FRAME  = 2'd2;

  typedef logic [VRAM_AW-1:0] vaddr_t;

  typedef struct packed {
    logic       we;
    logic       re;
    vaddr_t     addr;
    logic [7:0] wdata;
  } vram_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] line;
    logic [4:0] tile_column;
    logic [7:0] pixels;
    logic       last;
  } res_t;

endpackage

### hdl/stbr_if.sv
// valid/ready channel interfaces for input items and result items
interface stbr_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [12:0]           vram_offset;
  logic [7:0]            write_data;

  modport source (output valid, action, vram_offset, write_data, input ready);
  modport sink   (input valid, action, vram_offset, write_data, output ready);
endinterface

interface stbr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] line;
  logic [4:0] tile_column;
  logic [7:0] pixels;
  logic       last;

  modport source (output valid, kind, line, tile_column, pixels, last, input ready);
  modport sink   (input valid, kind, line, tile_column, pixels, last, output ready);
endinterface

### hdl/stbr_vram.sv
// single port video ram with registered read data
module stbr_vram #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/stbr_seq.sv
// item sequencer: line timing, control register and tile fetch walk
module stbr_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [12:0]        in_offset,
  input  logic [7:0]         in_data,
  output logic               res_valid,
  input  logic               res_ready,
  output stbr_pkg::res_t     res,
  output stbr_pkg::vram_req_t vram_req,
  input  logic [7:0]         vram_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_MAP, S_LO, S_HI} state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       line_r, line_nxt;
  logic [15:0]      presc_r, presc_nxt;
  logic [15:0]      limit_r, limit_nxt;
  logic             en_r, en_nxt;
  logic [4:0]       col_r, col_nxt;
  logic [7:0]       lo_r, lo_nxt;
  stbr_pkg::vaddr_t base_r, base_nxt;
  logic             last_col;

  function automatic stbr_pkg::vaddr_t map_addr(input logic [7:0] row, input logic [4:0] col);
    map_addr = stbr_pkg::MAP_BASE + stbr_pkg::VRAM_AW'({row[7:3], 5'b0})
             + stbr_pkg::VRAM_AW'(col);
  endfunction

  assign last_col = (col_r == 5'(stbr_pkg::TILES_PER_LINE - 1));
  assign in_ready = (state_r == S_IDLE) && res_ready;

  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    presc_nxt = presc_r;
    limit_nxt = cfg_we ? cfg_wdata : limit_r;
    en_nxt    = en_r;
    col_nxt   = col_r;
    lo_nxt    = lo_r;
    base_nxt  = base_r;
    vram_req  = '0;
    res_valid = 1'b0;
    res       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          res_valid = 1'b1;
          res.kind  = stbr_pkg::KIND_STATUS;
          res.last  = 1'b1;
          case (in_action)
            stbr_pkg::ACT_VRAM_WR: begin
              vram_req.we    = 1'b1;
              vram_req.addr  = in_offset;
              vram_req.wdata = in_data;
            end
            stbr_pkg::ACT_CTRL_WR: begin
              en_nxt = in_data[7];
            end
            stbr_pkg::ACT_TICK: begin
              presc_nxt = presc_r + 16'd1;
              if (presc_r > limit_r) begin
                presc_nxt = '0;
                line_nxt  = (line_r >= 8'(stbr_pkg::LAST_LINE)) ? 8'd0 : line_r + 8'd1;
                if (en_r && line_nxt < 8'(stbr_pkg::VISIBLE_LINES)) begin
                  // row results come from the fetch walk, not from this beat
                  res_valid     = 1'b0;
                  col_nxt       = '0;
                  vram_req.re   = 1'b1;
                  vram_req.addr = map_addr(line_nxt, 5'd0);
                  state_nxt     = S_MAP;
                end else if (en_r && line_nxt == 8'(stbr_pkg::VISIBLE_LINES)) begin
                  res.kind = stbr_pkg::KIND_FRAME;
                end
              end
            end
            default: begin
            end
          endcase
          res.line = line_nxt;
        end
      end
      S_MAP: begin
        // tile index is back, fetch low plane of this row
        base_nxt      = stbr_pkg::VRAM_AW'({vram_rdata, 4'b0})
                      + stbr_pkg::VRAM_AW'({line_r[2:0], 1'b0});
        vram_req.re   = 1'b1;
        vram_req.addr = base_nxt;
        state_nxt     = S_LO;
      end
      S_LO: begin
        lo_nxt        = vram_rdata;
        vram_req.re   = 1'b1;
        vram_req.addr = base_r | stbr_pkg::VRAM_AW'(1);
        state_nxt     = S_HI;
      end
      S_HI: begin
        // read data holds while no read is issued, so a stall is safe
        res_valid       = 1'b1;
        res.kind        = stbr_pkg::KIND_ROW;
        res.line        = line_r;
        res.tile_column = col_r;
        res.pixels      = lo_r | vram_rdata;
        res.last        = last_col;
        if (res_ready) begin
          if (last_col) begin
            state_nxt = S_IDLE;
          end else begin
            col_nxt       = col_r + 5'd1;
            vram_req.re   = 1'b1;
            vram_req.addr = map_addr(line_r, col_nxt);
            state_nxt     = S_MAP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      line_r  <= stbr_pkg::LINE_RESET;
      presc_r <= '0;
      limit_r <= stbr_pkg::PRESCALE_RESET;
      en_r    <= 1'b0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
      presc_r <= presc_nxt;
      limit_r <= limit_nxt;
      en_r    <= en_nxt;
      col_r   <= col_nxt;
    end
    lo_r   <= lo_nxt;
    base_r <= base_nxt;
  end

endmodule

### hdl/scanline_tile_background_renderer_core.sv
// top level: sequencer, video ram and result output register
// a status or frame beat is registered and shows on the output in the cycle after its input beat
// an enabled visible line gives 20 row beats, each from a map, a low plane and a high plane
//   read in turn through the single video ram read port
// throughput: one input beat per cycle, none during a fetch or an output stall
// reset: synchronous active low, clears line to 144, prescaler, enable, limit to 279;
//   video ram is not cleared and holds garbage until written
module scanline_tile_background_renderer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  stbr_in_if.sink           in_ch,
  stbr_out_if.source        out_ch
);

  logic                 res_valid;
  logic                 res_ready;
  stbr_pkg::res_t       res;
  stbr_pkg::vram_req_t  vram_req;
  logic [7:0]           vram_rdata;

  // output register, result side parted from the sequencer
  logic                 out_valid_r, out_valid_nxt;
  stbr_pkg::res_t       out_data_r;

  // sequencer owns all timing and fetch state
  stbr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_action  (in_ch.action),
    .in_offset  (in_ch.vram_offset),
    .in_data    (in_ch.write_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .vram_req   (vram_req),
    .vram_rdata (vram_rdata)
  );

  // tile map and tile data share this one array
  stbr_vram #(
    .ADDR_W (stbr_pkg::VRAM_AW),
    .DATA_W (8)
  ) u_vram (
    .clk   (clk),
    .we    (vram_req.we),
    .re    (vram_req.re),
    .addr  (vram_req.addr),
    .wdata (vram_req.wdata),
    .rdata (vram_rdata)
  );

  // register accepts a new beat when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_data_r.kind;
  assign out_ch.line        = out_data_r.line;
  assign out_ch.tile_column = out_data_r.tile_column;
  assign out_ch.pixels      = out_data_r.pixels;
  assign out_ch.last        = out_data_r.last;

  // the only read on an accepting cycle is the map fetch started by a tick
  a_read_on_accept_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (vram_req.re && in_ch.valid && in_ch.ready) |-> in_ch.action == stbr_pkg::ACT_TICK)
    else $error("video ram read on a non-tick input beat");

  // ram port does one thing per cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    vram_req.we |-> !vram_req.re)
    else $error("video ram read and write in the same cycle");

  // line counter stays in range on every result
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.line <= 8'(stbr_pkg::LAST_LINE))
    else $error("line out of range");

  // last row beat sits on the final tile column
  a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == stbr_pkg::KIND_ROW) |->
      (out_ch.last == (out_ch.tile_column == 5'(stbr_pkg::TILES_PER_LINE - 1))))
    else $error("row beat last flag does not match column");

endmodule
